### rtl/virtual_trackball_rotation_core_defines.svh
// assertion macros shared by the checker of the trackball rotation core
// expects clk and rst_n in the scope where a macro is used
`ifndef VIRTUAL_TRACKBALL_ROTATION_CORE_DEFINES_SVH
`define VIRTUAL_TRACKBALL_ROTATION_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VTR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define VTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vtr_pkg.sv
// types, constants, rounding helpers and the move microcode for the trackball core
// no dependencies
package vtr_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int OPW        = 18;   // multiplier operand width
  localparam int ACCW       = 48;   // accumulator and dividend width
  localparam int DENW       = 32;   // divisor width
  localparam int MUL_STEPS  = OPW;
  localparam int DIV_STEPS  = ACCW;
  localparam int SQRT_STEPS = 16;

  localparam logic signed [ACCW-1:0] ONE_W   = ACCW'(1) << FRAC_BITS;
  localparam logic signed [ACCW-1:0] NONE_W  = -(ACCW'(1) << FRAC_BITS);
  localparam logic signed [ACCW-1:0] ONE_SQ  = ACCW'(1) << (2 * FRAC_BITS);
  localparam logic signed [15:0]     ONE_M   = 16'(1) << FRAC_BITS;
  localparam logic signed [OPW-1:0]  ONE_OP  = OPW'(1) << FRAC_BITS;
  localparam logic signed [OPW-1:0]  NONE_OP = -(OPW'(1) << FRAC_BITS);

  typedef struct packed {
    logic               kind;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] rot_r0c0;
    logic signed [15:0] rot_r0c1;
    logic signed [15:0] rot_r0c2;
    logic signed [15:0] rot_r1c0;
    logic signed [15:0] rot_r1c1;
    logic signed [15:0] rot_r1c2;
    logic signed [15:0] rot_r2c0;
    logic signed [15:0] rot_r2c1;
    logic signed [15:0] rot_r2c2;
  } out_word_t;

  typedef enum logic [1:0] {
    SU_MUL  = 2'd0,
    SU_DIV  = 2'd1,
    SU_SQRT = 2'd2
  } su_op_t;

  typedef struct packed {
    logic                   start;
    su_op_t                 op;
    logic signed [OPW-1:0]  a;
    logic signed [OPW-1:0]  b;
    logic [ACCW-1:0]        num;
    logic [DENW-1:0]        den;
  } su_req_t;

  typedef struct packed {
    logic            done;
    logic [ACCW-1:0] value;
  } su_rsp_t;

  typedef enum logic [2:0] {
    UC_MAC  = 3'd0,
    UC_RND  = 3'd1,
    UC_N2   = 3'd2,
    UC_ZCHK = 3'd3,
    UC_DIV  = 3'd4,
    UC_END  = 3'd5
  } uc_op_t;

  typedef enum logic [3:0] {
    SRC_A0 = 4'd0,
    SRC_A1 = 4'd1,
    SRC_A2 = 4'd2,
    SRC_P0 = 4'd3,
    SRC_P1 = 4'd4,
    SRC_P2 = 4'd5,
    SRC_W  = 4'd6,
    SRC_VX = 4'd7,
    SRC_VY = 4'd8,
    SRC_VZ = 4'd9
  } src_t;

  // rotation entries take the low codes so the code is the entry index
  typedef enum logic [3:0] {
    DST_RM0 = 4'd0,
    DST_RM1 = 4'd1,
    DST_RM2 = 4'd2,
    DST_RM3 = 4'd3,
    DST_RM4 = 4'd4,
    DST_RM5 = 4'd5,
    DST_RM6 = 4'd6,
    DST_RM7 = 4'd7,
    DST_RM8 = 4'd8,
    DST_W   = 4'd9,
    DST_VX  = 4'd10,
    DST_VY  = 4'd11,
    DST_VZ  = 4'd12
  } dst_t;

  typedef struct packed {
    uc_op_t op;
    src_t   sa;
    src_t   sb;
    logic   neg;
    logic   clr;
    logic   flg;   // clamp for rounding, doubled numerator for division
    dst_t   dst;
  } uc_t;

  function automatic uc_t uc_mac(src_t sa, src_t sb, logic neg, logic clr);
    uc_t u;
    u     = '0;
    u.op  = UC_MAC;
    u.sa  = sa;
    u.sb  = sb;
    u.neg = neg;
    u.clr = clr;
    return u;
  endfunction

  function automatic uc_t uc_rnd(dst_t dst, logic clamp);
    uc_t u;
    u     = '0;
    u.op  = UC_RND;
    u.flg = clamp;
    u.dst = dst;
    return u;
  endfunction

  function automatic uc_t uc_div(dst_t dst, logic dbl);
    uc_t u;
    u     = '0;
    u.op  = UC_DIV;
    u.flg = dbl;
    u.dst = dst;
    return u;
  endfunction

  function automatic uc_t uc_ctl(uc_op_t op);
    uc_t u;
    u    = '0;
    u.op = op;
    return u;
  endfunction

  // move program: dot, cross, norm and the nine quadratic forms
  function automatic uc_t ucode_rom(logic [5:0] pc);
    unique case (pc)
      6'd0:  return uc_mac(SRC_A0, SRC_P0, 1'b0, 1'b1);
      6'd1:  return uc_mac(SRC_A1, SRC_P1, 1'b0, 1'b0);
      6'd2:  return uc_mac(SRC_A2, SRC_P2, 1'b0, 1'b0);
      6'd3:  return uc_rnd(DST_W, 1'b1);
      6'd4:  return uc_mac(SRC_A1, SRC_P2, 1'b0, 1'b1);
      6'd5:  return uc_mac(SRC_A2, SRC_P1, 1'b1, 1'b0);
      6'd6:  return uc_rnd(DST_VX, 1'b0);
      6'd7:  return uc_mac(SRC_A2, SRC_P0, 1'b0, 1'b1);
      6'd8:  return uc_mac(SRC_A0, SRC_P2, 1'b1, 1'b0);
      6'd9:  return uc_rnd(DST_VY, 1'b0);
      6'd10: return uc_mac(SRC_A0, SRC_P1, 1'b0, 1'b1);
      6'd11: return uc_mac(SRC_A1, SRC_P0, 1'b1, 1'b0);
      6'd12: return uc_rnd(DST_VZ, 1'b0);
      6'd13: return uc_ctl(UC_ZCHK);
      6'd14: return uc_mac(SRC_W,  SRC_W,  1'b0, 1'b1);
      6'd15: return uc_mac(SRC_VX, SRC_VX, 1'b0, 1'b0);
      6'd16: return uc_mac(SRC_VY, SRC_VY, 1'b0, 1'b0);
      6'd17: return uc_mac(SRC_VZ, SRC_VZ, 1'b0, 1'b0);
      6'd18: return uc_ctl(UC_N2);
      6'd19: return uc_mac(SRC_W,  SRC_W,  1'b0, 1'b1);
      6'd20: return uc_mac(SRC_VX, SRC_VX, 1'b0, 1'b0);
      6'd21: return uc_mac(SRC_VY, SRC_VY, 1'b1, 1'b0);
      6'd22: return uc_mac(SRC_VZ, SRC_VZ, 1'b1, 1'b0);
      6'd23: return uc_div(DST_RM0, 1'b0);
      6'd24: return uc_mac(SRC_VX, SRC_VY, 1'b0, 1'b1);
      6'd25: return uc_mac(SRC_W,  SRC_VZ, 1'b1, 1'b0);
      6'd26: return uc_div(DST_RM1, 1'b1);
      6'd27: return uc_mac(SRC_VX, SRC_VZ, 1'b0, 1'b1);
      6'd28: return uc_mac(SRC_W,  SRC_VY, 1'b0, 1'b0);
      6'd29: return uc_div(DST_RM2, 1'b1);
      6'd30: return uc_mac(SRC_VX, SRC_VY, 1'b0, 1'b1);
      6'd31: return uc_mac(SRC_W,  SRC_VZ, 1'b0, 1'b0);
      6'd32: return uc_div(DST_RM3, 1'b1);
      6'd33: return uc_mac(SRC_W,  SRC_W,  1'b0, 1'b1);
      6'd34: return uc_mac(SRC_VX, SRC_VX, 1'b1, 1'b0);
      6'd35: return uc_mac(SRC_VY, SRC_VY, 1'b0, 1'b0);
      6'd36: return uc_mac(SRC_VZ, SRC_VZ, 1'b1, 1'b0);
      6'd37: return uc_div(DST_RM4, 1'b0);
      6'd38: return uc_mac(SRC_VY, SRC_VZ, 1'b0, 1'b1);
      6'd39: return uc_mac(SRC_W,  SRC_VX, 1'b1, 1'b0);
      6'd40: return uc_div(DST_RM5, 1'b1);
      6'd41: return uc_mac(SRC_VX, SRC_VZ, 1'b0, 1'b1);
      6'd42: return uc_mac(SRC_W,  SRC_VY, 1'b1, 1'b0);
      6'd43: return uc_div(DST_RM6, 1'b1);
      6'd44: return uc_mac(SRC_VY, SRC_VZ, 1'b0, 1'b1);
      6'd45: return uc_mac(SRC_W,  SRC_VX, 1'b0, 1'b0);
      6'd46: return uc_div(DST_RM7, 1'b1);
      6'd47: return uc_mac(SRC_W,  SRC_W,  1'b0, 1'b1);
      6'd48: return uc_mac(SRC_VX, SRC_VX, 1'b1, 1'b0);
      6'd49: return uc_mac(SRC_VY, SRC_VY, 1'b1, 1'b0);
      6'd50: return uc_mac(SRC_VZ, SRC_VZ, 1'b0, 1'b0);
      6'd51: return uc_div(DST_RM8, 1'b0);
      default: return uc_ctl(UC_END);
    endcase
  endfunction

  // divide by 2^FRAC_BITS, nearest, ties away from zero
  function automatic logic signed [ACCW-1:0] rnd_frac(logic signed [ACCW-1:0] v);
    logic [ACCW-1:0] mag;
    logic [ACCW-1:0] r;
    mag = v[ACCW-1] ? ACCW'(-v) : ACCW'(v);
    r   = (mag + (ACCW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[ACCW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [OPW-1:0] clamp_one(logic signed [ACCW-1:0] v);
    if (v > ONE_W) return ONE_OP;
    if (v < NONE_W) return NONE_OP;
    return v[OPW-1:0];
  endfunction

  // row-major index of a 3x3 entry
  function automatic logic [3:0] idx3(logic [1:0] r, logic [1:0] c);
    return 4'({r, 1'b0}) + 4'(r) + 4'(c);
  endfunction

endpackage

### rtl/vtr_serial_unit.sv
// shared bit-serial arithmetic unit: signed multiply, unsigned divide, rounded square root
// uses vtr_pkg for the request and response words
module vtr_serial_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  vtr_pkg::su_req_t req,
  output vtr_pkg::su_rsp_t rsp
);

  localparam int AW = vtr_pkg::ACCW;
  localparam int CW = $clog2(vtr_pkg::DIV_STEPS);
  localparam int OW = vtr_pkg::OPW;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic            neg_r, neg_nxt;
  vtr_pkg::su_op_t op_r, op_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   wa_r, wa_nxt;   // multiplicand / dividend-quotient / radicand
  logic [AW-1:0]   wb_r, wb_nxt;   // multiplier / remainder
  logic [AW-1:0]   wc_r, wc_nxt;   // product / divisor / root
  logic [AW-1:0]   rem_div, rem_sqrt, trial;
  logic [OW-1:0]   mag_a, mag_b;

  assign mag_a    = req.a[OW-1] ? OW'(-req.a) : OW'(req.a);
  assign mag_b    = req.b[OW-1] ? OW'(-req.b) : OW'(req.b);
  assign rem_div  = {wb_r[AW-2:0], wa_r[AW-1]};
  assign rem_sqrt = {wb_r[AW-3:0], wa_r[AW-1:AW-2]};
  assign trial    = {wc_r[AW-3:0], 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    wa_nxt   = wa_r;
    wb_nxt   = wb_r;
    wc_nxt   = wc_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        neg_nxt  = req.a[OW-1] ^ req.b[OW-1];
        unique case (req.op)
          vtr_pkg::SU_MUL: begin
            wa_nxt  = AW'(mag_a);
            wb_nxt  = AW'(mag_b);
            wc_nxt  = '0;
            cnt_nxt = CW'(vtr_pkg::MUL_STEPS - 1);
          end
          vtr_pkg::SU_DIV: begin
            wa_nxt  = req.num;
            wb_nxt  = '0;
            wc_nxt  = AW'(req.den);
            cnt_nxt = CW'(vtr_pkg::DIV_STEPS - 1);
          end
          vtr_pkg::SU_SQRT: begin
            wa_nxt  = {req.num[31:0], {(AW - 32){1'b0}}};
            wb_nxt  = '0;
            wc_nxt  = '0;
            cnt_nxt = CW'(vtr_pkg::SQRT_STEPS - 1);
          end
          default: busy_nxt = 1'b0;
        endcase
      end
    end else begin
      unique case (op_r)
        vtr_pkg::SU_MUL: begin
          if (wb_r[0]) wc_nxt = wc_r + wa_r;
          wa_nxt = {wa_r[AW-2:0], 1'b0};
          wb_nxt = {1'b0, wb_r[AW-1:1]};
        end
        vtr_pkg::SU_DIV: begin
          if (rem_div >= wc_r) begin
            wb_nxt = rem_div - wc_r;
            wa_nxt = {wa_r[AW-2:0], 1'b1};
          end else begin
            wb_nxt = rem_div;
            wa_nxt = {wa_r[AW-2:0], 1'b0};
          end
        end
        vtr_pkg::SU_SQRT: begin
          // two radicand bits per step, one root bit
          if (rem_sqrt >= trial) begin
            wb_nxt = rem_sqrt - trial;
            wc_nxt = {wc_r[AW-2:0], 1'b1};
          end else begin
            wb_nxt = rem_sqrt;
            wc_nxt = {wc_r[AW-2:0], 1'b0};
          end
          wa_nxt = {wa_r[AW-3:0], 2'b00};
        end
        default: ;
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= vtr_pkg::SU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    wa_r  <= wa_nxt;
    wb_r  <= wb_nxt;
    wc_r  <= wc_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    case (op_r)
      vtr_pkg::SU_MUL:  rsp.value = neg_r ? AW'(-wc_r) : wc_r;
      vtr_pkg::SU_DIV:  rsp.value = wa_r;
      // remainder above the root means the upper neighbor is closer
      vtr_pkg::SU_SQRT: rsp.value = (wb_r > wc_r) ? wc_r + AW'(1) : wc_r;
      default:          rsp.value = '0;
    endcase
  end

endmodule

### rtl/virtual_trackball_rotation_core.sv
// Virtual trackball rotation core. Each pointer word (press or move, signed Q2.14 x and y)
// is mapped onto the unit sphere; a press sets the anchor and latches the current rotation
// as base, a move rotates the base by the quaternion of anchor and point. Every word
// returns the current 3x3 rotation in Q2.14. One word is processed at a time, and every
// multiply, divide and square root runs through a single bit-serial unit. A point outside
// the unit circle adds two divides; a move runs 37 multiplies and 9 divides for the
// rotation and 27 multiplies for the matrix product, or stops after the first 9 multiplies
// when the rotation axis comes out zero. The next word is taken while a result waits.
// depends on vtr_pkg and vtr_serial_unit
module virtual_trackball_rotation_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vtr_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vtr_pkg::out_word_t  out_word
);

  localparam int OW = vtr_pkg::OPW;
  localparam int AW = vtr_pkg::ACCW;
  localparam int FB = vtr_pkg::FRAC_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_ROOT = 7'b0000100,
    S_NORM = 7'b0001000,
    S_PROG = 7'b0010000,
    S_MAT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   step_r, step_nxt;
  logic   pend_r, pend_nxt;
  logic   kind_r, kind_nxt;
  logic   inside_r, inside_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [1:0] mi_r, mi_nxt, mj_r, mj_nxt, mk_r, mk_nxt;
  logic signed [15:0] x_r, x_nxt, y_r, y_nxt;
  logic [15:0] len_r, len_nxt;
  logic signed [15:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [15:0] a0_r, a0_nxt, a1_r, a1_nxt, a2_r, a2_nxt;
  logic signed [OW-1:0] w_r, w_nxt, vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic [31:0] n2_r, n2_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [OW-1:0] rm_r [9];
  logic signed [OW-1:0] rm_nxt [9];
  logic signed [15:0] base_r [9];
  logic signed [15:0] base_nxt [9];
  logic signed [15:0] cur_r [9];
  logic signed [15:0] cur_nxt [9];
  logic out_valid_r, out_valid_nxt;
  vtr_pkg::out_word_t out_word_r, out_word_nxt;

  vtr_pkg::su_req_t req;
  vtr_pkg::su_rsp_t rsp;
  vtr_pkg::uc_t     uc;

  logic signed [AW-1:0] prod, mac_sum, rnd_v;
  logic signed [OW-1:0] src_a, src_b, div_q;
  logic signed [15:0]   norm_src;
  logic [AW-1:0]        acc_mag;
  logic [16:0]          norm_mag;
  logic [3:0]           ix_a, ix_b, ix_c;

  vtr_serial_unit u_su (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign prod     = $signed(rsp.value);
  assign uc       = vtr_pkg::ucode_rom(pc_r);
  assign acc_mag  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign norm_src = step_r ? y_r : x_r;
  assign norm_mag = norm_src[15] ? 17'(-17'(norm_src)) : 17'(norm_src);
  assign ix_a     = vtr_pkg::idx3(mi_r, mk_r);
  assign ix_b     = vtr_pkg::idx3(mk_r, mj_r);
  assign ix_c     = vtr_pkg::idx3(mi_r, mj_r);
  assign rnd_v    = vtr_pkg::rnd_frac(acc_r);

  always_comb begin
    case (uc.sa)
      vtr_pkg::SRC_A0: src_a = OW'(a0_r);
      vtr_pkg::SRC_A1: src_a = OW'(a1_r);
      vtr_pkg::SRC_A2: src_a = OW'(a2_r);
      vtr_pkg::SRC_W:  src_a = w_r;
      vtr_pkg::SRC_VX: src_a = vx_r;
      vtr_pkg::SRC_VY: src_a = vy_r;
      vtr_pkg::SRC_VZ: src_a = vz_r;
      default:         src_a = '0;
    endcase
    case (uc.sb)
      vtr_pkg::SRC_P0: src_b = OW'(p0_r);
      vtr_pkg::SRC_P1: src_b = OW'(p1_r);
      vtr_pkg::SRC_P2: src_b = OW'(p2_r);
      vtr_pkg::SRC_W:  src_b = w_r;
      vtr_pkg::SRC_VX: src_b = vx_r;
      vtr_pkg::SRC_VY: src_b = vy_r;
      vtr_pkg::SRC_VZ: src_b = vz_r;
      default:         src_b = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pend_nxt      = pend_r;
    kind_nxt      = kind_r;
    inside_nxt    = inside_r;
    pc_nxt        = pc_r;
    mi_nxt        = mi_r;
    mj_nxt        = mj_r;
    mk_nxt        = mk_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    len_nxt       = len_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    a0_nxt        = a0_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    w_nxt         = w_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vz_nxt        = vz_r;
    n2_nxt        = n2_r;
    acc_nxt       = acc_r;
    rm_nxt        = rm_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    mac_sum       = '0;
    div_q         = '0;
    req           = '0;
    req.op        = vtr_pkg::SU_MUL;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_word.kind;
          x_nxt     = in_word.x_pos;
          y_nxt     = in_word.y_pos;
          step_nxt  = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = S_SQ;
        end
      end

      S_SQ: begin
        req.op = vtr_pkg::SU_MUL;
        req.a  = OW'(norm_src);
        req.b  = OW'(norm_src);
        if (!pend_r) begin
          req.start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (rsp.done) begin
          pend_nxt = 1'b0;
          mac_sum  = (step_r ? acc_r : '0) + prod;
          acc_nxt  = mac_sum;
          if (!step_r) begin
            step_nxt = 1'b1;
          end else begin
            // exactly on the unit circle goes the scaling way
            inside_nxt = mac_sum < vtr_pkg::ONE_SQ;
            state_nxt  = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        req.op  = vtr_pkg::SU_SQRT;
        req.num = inside_r ? AW'(vtr_pkg::ONE_SQ - acc_r) : AW'(acc_r);
        if (!pend_r) begin
          req.start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (rsp.done) begin
          pend_nxt = 1'b0;
          if (inside_r) begin
            p0_nxt = x_r;
            p1_nxt = y_r;
            p2_nxt = $signed(rsp.value[15:0]);
          end else begin
            len_nxt   = rsp.value[15:0];
            p2_nxt    = '0;
            step_nxt  = 1'b0;
            state_nxt = S_NORM;
          end
        end
      end

      S_NORM: begin
        req.op  = vtr_pkg::SU_DIV;
        req.num = (AW'(norm_mag) << FB) + AW'(len_r >> 1);
        req.den = vtr_pkg::DENW'(len_r);
        if (!pend_r) begin
          req.start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (rsp.done) begin
          pend_nxt = 1'b0;
          div_q    = $signed(rsp.value[OW-1:0]);
          if (norm_src[15]) div_q = -div_q;
          if (!step_r) begin
            p0_nxt   = div_q[15:0];
            step_nxt = 1'b1;
          end else begin
            p1_nxt = div_q[15:0];
          end
        end
      end

      S_PROG: begin
        case (uc.op)
          vtr_pkg::UC_MAC: begin
            req.op = vtr_pkg::SU_MUL;
            req.a  = src_a;
            req.b  = src_b;
            if (!pend_r) begin
              req.start = 1'b1;
              pend_nxt  = 1'b1;
            end else if (rsp.done) begin
              pend_nxt = 1'b0;
              mac_sum  = uc.clr ? '0 : acc_r;
              acc_nxt  = uc.neg ? mac_sum - prod : mac_sum + prod;
              pc_nxt   = pc_r + 6'd1;
            end
          end
          vtr_pkg::UC_RND: begin
            div_q = uc.flg ? vtr_pkg::clamp_one(rnd_v) : rnd_v[OW-1:0];
            case (uc.dst)
              vtr_pkg::DST_W:  w_nxt  = div_q;
              vtr_pkg::DST_VX: vx_nxt = div_q;
              vtr_pkg::DST_VY: vy_nxt = div_q;
              default:         vz_nxt = div_q;
            endcase
            pc_nxt = pc_r + 6'd1;
          end
          vtr_pkg::UC_N2: begin
            n2_nxt = acc_r[31:0];
            pc_nxt = pc_r + 6'd1;
          end
          vtr_pkg::UC_ZCHK: begin
            // no axis: the rotation is the identity
            if (vx_r == '0 && vy_r == '0 && vz_r == '0) begin
              cur_nxt   = base_r;
              state_nxt = S_DONE;
            end else begin
              pc_nxt = pc_r + 6'd1;
            end
          end
          vtr_pkg::UC_DIV: begin
            req.op  = vtr_pkg::SU_DIV;
            req.num = (uc.flg ? acc_mag << (FB + 1) : acc_mag << FB) + AW'(n2_r >> 1);
            req.den = n2_r;
            if (!pend_r) begin
              req.start = 1'b1;
              pend_nxt  = 1'b1;
            end else if (rsp.done) begin
              pend_nxt = 1'b0;
              div_q    = $signed(rsp.value[OW-1:0]);
              if (acc_r[AW-1]) div_q = -div_q;
              rm_nxt[uc.dst] = div_q;
              pc_nxt   = pc_r + 6'd1;
            end
          end
          default: begin
            mi_nxt    = '0;
            mj_nxt    = '0;
            mk_nxt    = '0;
            state_nxt = S_MAT;
          end
        endcase
      end

      S_MAT: begin
        if (mk_r == 2'd3) begin
          div_q         = vtr_pkg::clamp_one(rnd_v);
          cur_nxt[ix_c] = div_q[15:0];
          mk_nxt        = '0;
          if (mj_r == 2'd2) begin
            mj_nxt = '0;
            if (mi_r == 2'd2) state_nxt = S_DONE;
            else mi_nxt = mi_r + 2'd1;
          end else begin
            mj_nxt = mj_r + 2'd1;
          end
        end else begin
          req.op = vtr_pkg::SU_MUL;
          req.a  = rm_r[ix_a];
          req.b  = OW'(base_r[ix_b]);
          if (!pend_r) begin
            req.start = 1'b1;
            pend_nxt  = 1'b1;
          end else if (rsp.done) begin
            pend_nxt = 1'b0;
            acc_nxt  = ((mk_r == 2'd0) ? '0 : acc_r) + prod;
            mk_nxt   = mk_r + 2'd1;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt.rot_r0c0 = cur_r[0];
          out_word_nxt.rot_r0c1 = cur_r[1];
          out_word_nxt.rot_r0c2 = cur_r[2];
          out_word_nxt.rot_r1c0 = cur_r[3];
          out_word_nxt.rot_r1c1 = cur_r[4];
          out_word_nxt.rot_r1c2 = cur_r[5];
          out_word_nxt.rot_r2c0 = cur_r[6];
          out_word_nxt.rot_r2c1 = cur_r[7];
          out_word_nxt.rot_r2c2 = cur_r[8];
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // sphere point ready: a press latches anchor and base, a move runs the program
    if ((state_r == S_ROOT && pend_r && rsp.done && inside_r) ||
        (state_r == S_NORM && pend_r && rsp.done && step_r)) begin
      if (!kind_r) begin
        a0_nxt    = p0_nxt;
        a1_nxt    = p1_nxt;
        a2_nxt    = p2_nxt;
        base_nxt  = cur_r;
        state_nxt = S_DONE;
      end else begin
        pc_nxt    = '0;
        state_nxt = S_PROG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      a0_r        <= '0;
      a1_r        <= '0;
      a2_r        <= vtr_pkg::ONE_M;
      for (int i = 0; i < 9; i++) begin
        base_r[i] <= (i == 0 || i == 4 || i == 8) ? vtr_pkg::ONE_M : 16'sd0;
        cur_r[i]  <= (i == 0 || i == 4 || i == 8) ? vtr_pkg::ONE_M : 16'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      a0_r        <= a0_nxt;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      base_r      <= base_nxt;
      cur_r       <= cur_nxt;
    end
    step_r     <= step_nxt;
    kind_r     <= kind_nxt;
    inside_r   <= inside_nxt;
    pc_r       <= pc_nxt;
    mi_r       <= mi_nxt;
    mj_r       <= mj_nxt;
    mk_r       <= mk_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    len_r      <= len_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    w_r        <= w_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    vz_r       <= vz_nxt;
    n2_r       <= n2_nxt;
    acc_r      <= acc_nxt;
    rm_r       <= rm_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/vtr_checker.sv
// port-level checks for the trackball rotation core, bound to the top level
// depends on vtr_pkg and the assertion macro header
`include "virtual_trackball_rotation_core_defines.svh"

module vtr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input vtr_pkg::out_word_t out_word
);

  logic range_ok;
  logic in_take;

  assign in_take = in_valid && !in_stall;

  // every rotation entry stays within [-1, 1]
  assign range_ok =
    (out_word.rot_r0c0 <= 16'sd16384) && (out_word.rot_r0c0 >= -16'sd16384) &&
    (out_word.rot_r0c1 <= 16'sd16384) && (out_word.rot_r0c1 >= -16'sd16384) &&
    (out_word.rot_r0c2 <= 16'sd16384) && (out_word.rot_r0c2 >= -16'sd16384) &&
    (out_word.rot_r1c0 <= 16'sd16384) && (out_word.rot_r1c0 >= -16'sd16384) &&
    (out_word.rot_r1c1 <= 16'sd16384) && (out_word.rot_r1c1 >= -16'sd16384) &&
    (out_word.rot_r1c2 <= 16'sd16384) && (out_word.rot_r1c2 >= -16'sd16384) &&
    (out_word.rot_r2c0 <= 16'sd16384) && (out_word.rot_r2c0 >= -16'sd16384) &&
    (out_word.rot_r2c1 <= 16'sd16384) && (out_word.rot_r2c1 >= -16'sd16384) &&
    (out_word.rot_r2c2 <= 16'sd16384) && (out_word.rot_r2c2 >= -16'sd16384);

  `VTR_ASSERT_SAME(a_range, out_valid, range_ok, "rotation entry out of range")
  `VTR_ASSERT_NEXT(a_busy_after_take, in_take, in_stall, "input taken but core not busy")
  `VTR_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")
  `VTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind virtual_trackball_rotation_core vtr_checker u_vtr_checker (.*);
